// ===== rtl/core/jtks_pkg.sv =====
// Shared types and constants for the json top-level key scanner.
// Used by json_top_level_key_scanner_unit; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jtks_pkg;

	// field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned POS_W    = 16;
	localparam int unsigned DEPTH_W  = 8;
	localparam int unsigned IN_TDATA_W  = 8;
	// key_found + key_offset + key_length + scan_done = 34 bits, padded to 40
	localparam int unsigned OUT_FIELDS_W = 1 + POS_W + POS_W + 1;
	localparam int unsigned OUT_TDATA_W  = 40;

	// saturation limits
	localparam logic [POS_W-1:0]   POS_LIMIT   = 16'hFFFF;
	localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = 8'hFF;

	// character codes
	localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
	localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;
	localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;

	// scanner state
	typedef struct packed {
		logic [POS_W-1:0]   byte_position;
		logic [DEPTH_W-1:0] object_depth;
		logic [DEPTH_W-1:0] array_depth;
		logic               inside_string;
		logic               expect_key;
		logic               key_open;
		logic [POS_W-1:0]   key_begin;
		logic [BYTE_W-1:0]  prior_byte;
		logic               stopped;
	} scan_state_t;

	localparam scan_state_t SCAN_STATE_RESET = '0;

	// one result item
	typedef struct packed {
		logic             scan_done;
		logic [POS_W-1:0] key_length;
		logic [POS_W-1:0] key_offset;
		logic             key_found;
	} scan_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/json_top_level_key_scanner_unit.sv =====
// Top level of the json top-level key scanner: input register, scan logic,
// result register. Depends on jtks_pkg.
`timescale 1ns / 1ps
`default_nettype none

// channel     dir  signals                          transaction
// s_axis      in   tvalid tready tdata tlast        one text byte
// m_axis      out  tvalid tready tdata              one key report or done marker
//
// One byte per cycle sustained while m_axis takes every result; each byte passes
// through the input register and its result, if any, through the result register.
// arst_n clears both valid flags and the scan state; the byte after the
// last-flagged one starts a fresh text.
// A stalled m_axis holds the result register; the input register keeps
// draining bytes that produce no result and holds the first one that does.

module json_top_level_key_scanner_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// [7:0] text_byte
	input  wire logic [jtks_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// final_byte
	input  wire logic                               s_axis_tlast,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// [0] key_found, [16:1] key_offset, [32:17] key_length, [33] scan_done,
	// [39:34] zero
	output logic [jtks_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

	logic                          valid_s1;
	logic [jtks_pkg::BYTE_W-1:0]   byte_s1;
	logic                          last_s1;
	jtks_pkg::scan_state_t         state_q;
	jtks_pkg::scan_state_t         state_next;
	jtks_pkg::scan_result_t        result_next;
	jtks_pkg::scan_result_t        result_s2;
	logic                          has_result;
	logic                          out_free;
	logic                          consume_s1;
	logic                          valid_s2;

	// handshake: output slot free, input stage drains when its result fits
	assign out_free      = !valid_s2 || m_axis_tready;
	assign consume_s1    = valid_s1 && (!has_result || out_free);
	assign s_axis_tready = !valid_s1 || consume_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata[jtks_pkg::BYTE_W-1:0];
			last_s1 <= s_axis_tlast;
		end
	end

	// scan logic for the byte in the input register
	always_comb begin
		logic [jtks_pkg::POS_W-1:0] pos_inc;
		logic                       quote_ok;
		logic                       found;
		logic                       done;
		logic [jtks_pkg::POS_W-1:0] off;
		logic [jtks_pkg::POS_W-1:0] len;

		state_next = state_q;
		found      = 1'b0;
		done       = 1'b0;
		off        = '0;
		len        = '0;
		pos_inc    = (state_q.byte_position == jtks_pkg::POS_LIMIT) ?
			jtks_pkg::POS_LIMIT : state_q.byte_position + 1'b1;
		quote_ok   = (state_q.byte_position != '0) &&
			(state_q.prior_byte != jtks_pkg::CH_BACKSLASH);

		if (!state_q.stopped) begin
			// depth and flag effects of the byte
			case (byte_s1)
				jtks_pkg::CH_LBRACE: begin
					if (state_q.object_depth != jtks_pkg::DEPTH_LIMIT)
						state_next.object_depth = state_q.object_depth + 1'b1;
					state_next.expect_key = 1'b1;
				end
				jtks_pkg::CH_RBRACE: begin
					if (state_q.object_depth != '0)
						state_next.object_depth = state_q.object_depth - 1'b1;
				end
				jtks_pkg::CH_LBRACKET: begin
					if (state_q.array_depth != jtks_pkg::DEPTH_LIMIT)
						state_next.array_depth = state_q.array_depth + 1'b1;
				end
				jtks_pkg::CH_RBRACKET: begin
					if (state_q.array_depth != '0)
						state_next.array_depth = state_q.array_depth - 1'b1;
				end
				jtks_pkg::CH_COMMA: begin
					if (state_q.object_depth == 8'd1 && state_q.array_depth == '0)
						state_next.expect_key = 1'b1;
				end
				jtks_pkg::CH_COLON: begin
					state_next.expect_key = 1'b0;
				end
				jtks_pkg::CH_DQUOTE, jtks_pkg::CH_SQUOTE: begin
					if (quote_ok)
						state_next.inside_string = !state_q.inside_string;
				end
				default: begin
				end
			endcase

			// stop on depth zero, otherwise track top-level key strings
			if (state_next.object_depth == '0) begin
				state_next.stopped = 1'b1;
				done = 1'b1;
			end else if (state_next.object_depth == 8'd1 && state_next.array_depth == '0) begin
				if (state_next.inside_string && state_next.expect_key && !state_q.key_open) begin
					state_next.key_begin = pos_inc;
					state_next.key_open  = 1'b1;
				end else if (!state_next.inside_string && state_next.expect_key &&
					state_q.key_open) begin
					found = 1'b1;
					off   = state_q.key_begin;
					len   = (state_q.byte_position >= state_q.key_begin) ?
						state_q.byte_position - state_q.key_begin : '0;
					state_next.key_open = 1'b0;
				end
			end

			state_next.prior_byte    = byte_s1;
			state_next.byte_position = pos_inc;
		end

		// last byte of the text reports done and restarts the scanner
		if (last_s1) begin
			done       = 1'b1;
			state_next = jtks_pkg::SCAN_STATE_RESET;
		end

		has_result             = found || done;
		result_next.key_found  = found;
		result_next.key_offset = off;
		result_next.key_length = len;
		result_next.scan_done  = done;
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jtks_pkg::SCAN_STATE_RESET;
		end else if (consume_s1) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= consume_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && consume_s1 && has_result) begin
			result_s2 <= result_next;
		end
	end

	// output packing
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {
		{(jtks_pkg::OUT_TDATA_W - jtks_pkg::OUT_FIELDS_W){1'b0}},
		result_s2
	};

endmodule

`default_nettype wire
